### design/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared codes for the checked integer ALU
// Operation and status codes, default operand width.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

	localparam int unsigned DataWidthDef = 64;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

endpackage

`default_nettype wire

### design/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu: pipelined add/sub/mul/div/rem with range status
// Deep pipeline: decode stage, one restoring divide bit per stage, split
// multiplier, final sign fix-up and range check.
// ----------------------------------------------------------------------------
//
// Channel  | handshake           | payload
// ---------+---------------------+---------------------------------------------
// input    | in_valid / in_ready | operation, is_signed, operand_a, operand_b
// output   | out_valid/out_ready | value, status
//
// DATA_WIDTH+2 register stages, the same for every operation. The depth
// is set by the divider, which resolves one quotient bit per stage. One
// item enters per cycle while the pipe is not full or the output takes
// items. Each stage has its own ready, so bubbles close up while the output
// stalls and the input keeps taking items until the pipe is full. arst_n
// clears only the valid bits; data registers hold junk.
// ----------------------------------------------------------------------------
`default_nettype none

module checked_integer_alu #(
	parameter int unsigned DATA_WIDTH = cia_pkg::DataWidthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic        is_signed,
	input  wire logic [63:0] operand_a,
	input  wire logic [63:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value,
	output logic [1:0]       status
);

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned LO = (W + 1) / 2;  // low half of a multiplier operand
	localparam int unsigned HI = W - LO;
	localparam int unsigned N  = W + 2;        // decode + W divide steps + fix-up

	// rem/quo double as the product halves for multiply items
	typedef struct packed {
		cia_pkg::op_t     op;
		logic             sgn;
		logic             na;
		logic             nb;
		cia_pkg::status_t st;
		logic [W-1:0]     val;
		logic [W-1:0]     rem;
		logic [W-1:0]     quo;
		logic [W-1:0]     dvs;
	} item_t;

	item_t          pipe_s [N];
	item_t          nxt    [N];
	logic [N-1:0]   vld_s;
	logic [N:0]     rdy;

	// multiplier partial products, live beside stage 1
	logic [2*LO-1:0] pp_ll_s2;
	logic [LO+HI-1:0] pp_lh_s2, pp_hl_s2;
	logic [2*HI-1:0] pp_hh_s2;

	// one restoring divide step: next quotient bit enters at the bottom
	function automatic item_t div_step(input item_t x);
		item_t    y;
		logic [W:0] trial;
		y = x;
		trial = {x.rem, x.quo[W-1]} - {1'b0, x.dvs};
		if (!trial[W]) begin
			y.rem = trial[W-1:0];
		end else begin
			y.rem = {x.rem[W-2:0], x.quo[W-1]};
		end
		y.quo = {x.quo[W-2:0], ~trial[W]};
		return y;
	endfunction

	// sign fix-up and range check for multiply, divide and remainder
	function automatic item_t finish(input item_t x);
		item_t y;
		logic  neg;
		y = x;
		neg = x.na ^ x.nb;
		unique case (x.op)
			cia_pkg::OP_MUL: begin
				if (!x.sgn) begin
					if (x.rem != '0) y.st = cia_pkg::ST_OVER;
					else             y.val = x.quo;
				end else if (!neg && (x.rem != '0 || x.quo[W-1])) begin
					y.st = cia_pkg::ST_OVER;
				end else if (neg && (x.rem != '0 || (x.quo[W-1] && x.quo[W-2:0] != '0))) begin
					y.st = cia_pkg::ST_UNDER;
				end else begin
					y.val = neg ? -x.quo : x.quo;
				end
			end
			cia_pkg::OP_DIV: begin
				if (x.st == cia_pkg::ST_OK) begin
					if (!x.sgn)                y.val = x.quo;
					else if (!neg && x.quo[W-1]) y.st = cia_pkg::ST_OVER;
					else                       y.val = neg ? -x.quo : x.quo;
				end
			end
			cia_pkg::OP_REM: begin
				if (x.st == cia_pkg::ST_OK) y.val = x.na ? -x.rem : x.rem;
			end
			default: begin
			end
		endcase
		return y;
	endfunction

	// decode stage: mask operands, magnitudes, finish add and subtract
	always_comb begin
		logic [W-1:0] a, b;
		logic [W:0]   sum, dif;
		item_t        d;
		a   = operand_a[W-1:0];
		b   = operand_b[W-1:0];
		sum = {1'b0, a} + {1'b0, b};
		dif = {1'b0, a} - {1'b0, b};
		d.op  = cia_pkg::op_t'(operation);
		d.sgn = is_signed;
		d.na  = is_signed & a[W-1];
		d.nb  = is_signed & b[W-1];
		d.st  = cia_pkg::ST_OK;
		d.val = '0;
		d.rem = '0;
		d.quo = d.na ? -a : a;
		d.dvs = d.nb ? -b : b;
		unique case (d.op)
			cia_pkg::OP_ADD: begin
				if (!is_signed) begin
					if (sum[W]) d.st = cia_pkg::ST_OVER;
					else        d.val = sum[W-1:0];
				end else if (!d.na && !d.nb && sum[W-1]) begin
					d.st = cia_pkg::ST_OVER;
				end else if (d.na && d.nb && !sum[W-1]) begin
					d.st = cia_pkg::ST_UNDER;
				end else begin
					d.val = sum[W-1:0];
				end
			end
			cia_pkg::OP_SUB: begin
				if (!is_signed) begin
					if (dif[W]) d.st = cia_pkg::ST_UNDER;
					else        d.val = dif[W-1:0];
				end else if (!d.na && d.nb && dif[W-1]) begin
					d.st = cia_pkg::ST_OVER;
				end else if (d.na && !d.nb && !dif[W-1]) begin
					d.st = cia_pkg::ST_UNDER;
				end else begin
					d.val = dif[W-1:0];
				end
			end
			cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
				if (b == '0) d.st = cia_pkg::ST_DIVZ;
			end
			default: begin
			end
		endcase
		nxt[0] = d;
	end

	// divider steps, product assembly, final fix-up
	always_comb begin
		logic [2*W-1:0] prod;
		prod = {{(2*W-2*LO){1'b0}}, pp_ll_s2}
			+ ({{(2*W-LO-HI){1'b0}}, pp_lh_s2} << LO)
			+ ({{(2*W-LO-HI){1'b0}}, pp_hl_s2} << LO)
			+ ({{(2*W-2*HI){1'b0}}, pp_hh_s2} << (2*LO));
		for (int k = 1; k < N; k++) begin
			nxt[k] = pipe_s[k-1];
			if (k <= W) begin
				if ((pipe_s[k-1].op == cia_pkg::OP_DIV || pipe_s[k-1].op == cia_pkg::OP_REM)
						&& pipe_s[k-1].st == cia_pkg::ST_OK) begin
					nxt[k] = div_step(pipe_s[k-1]);
				end
				if (k == 2 && pipe_s[k-1].op == cia_pkg::OP_MUL) begin
					nxt[k].rem = prod[2*W-1:W];
					nxt[k].quo = prod[W-1:0];
				end
			end else begin
				nxt[k] = finish(pipe_s[k-1]);
			end
		end
	end

	// per-stage ready lets bubbles collapse under an output stall
	always_comb begin
		rdy[N] = out_ready;
		for (int k = N - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) vld_s[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (rdy[k]) pipe_s[k] <= nxt[k];
		end
		if (rdy[1]) begin
			pp_ll_s2 <= pipe_s[0].quo[LO-1:0] * pipe_s[0].dvs[LO-1:0];
			pp_lh_s2 <= pipe_s[0].quo[LO-1:0] * pipe_s[0].dvs[W-1:LO];
			pp_hl_s2 <= pipe_s[0].quo[W-1:LO] * pipe_s[0].dvs[LO-1:0];
			pp_hh_s2 <= pipe_s[0].quo[W-1:LO] * pipe_s[0].dvs[W-1:LO];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[N-1];
	assign value     = 64'(pipe_s[N-1].val);
	assign status    = pipe_s[N-1].st;

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cia_pkg::ST_OK |-> value == '0)
		else $error("nonzero value with error status");

	a_high_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value >> W) == '0)
		else $error("value bits above width set");

	a_decode_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !rdy[0] |=> vld_s[0] && $stable(pipe_s[0]))
		else $error("stalled decode stage changed");

endmodule

`default_nettype wire
